/* src/nrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nrp_pkg;

  localparam int unsigned TimeW = 32;

  // event kinds
  localparam logic [2:0] KIND_POLL       = 3'd0;
  localparam logic [2:0] KIND_LINK       = 3'd1;
  localparam logic [2:0] KIND_REGISTER   = 3'd2;
  localparam logic [2:0] KIND_PROV_DONE  = 3'd3;
  localparam logic [2:0] KIND_RESTART    = 3'd4;

  // poll actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_CONNECT   = 2'd1;
  localparam logic [1:0] ACT_PROVISION = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_START_CONFIGURED = 2'd0;
  localparam logic [1:0] REG_RECOVERY_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PROV_WINDOW      = 2'd2;

  localparam logic [TimeW-1:0] RECOVERY_TIMEOUT_RESET = 32'd300000;
  localparam logic [TimeW-1:0] PROV_WINDOW_RESET      = 32'd180000;

  typedef struct packed {
    logic [2:0]       kind;
    logic [TimeW-1:0] now_ms;
    logic             status_flag;
  } item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       provisioning_active;
  } result_t;

endpackage

`default_nettype wire

/* src/network_recovery_policy_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Network recovery policy. One event beat in, one result beat out, one beat per cycle
// while item_stall is low: the policy flags and both 32-bit timestamp compares are
// evaluated in the accept cycle; the result is registered in the output register, or in
// the skid entry while that stalls. A two-entry buffer keeps the event side accepting
// while a result waits; item_stall rises only when both entries are full. Config writes
// are always ready (cfg_ready tied high); an index past the three registers is ignored.
module network_recovery_policy_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  wire nrp_pkg::item_t   item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output nrp_pkg::result_t      result,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [31:0]            cfg_data
);
  import nrp_pkg::*;

  // configuration
  logic             start_configured;
  logic [TimeW-1:0] recovery_timeout_ms;
  logic [TimeW-1:0] provisioning_window_ms;

  // policy state
  logic             is_configured, is_configured_next;
  logic             link_up, link_up_next;
  logic             connect_attempted, connect_attempted_next;
  logic             in_provisioning, in_provisioning_next;
  logic             is_registered, is_registered_next;
  logic             provisioning_asked, provisioning_asked_next;
  logic             has_deadline, has_deadline_next;
  logic [TimeW-1:0] last_registered_time, last_registered_time_next;
  logic [TimeW-1:0] provisioning_start_time, provisioning_start_time_next;

  // output buffer
  logic    skid_valid;
  result_t skid;
  result_t res_next;

  logic             accept;
  logic [TimeW-1:0] since_start;
  logic [TimeW-1:0] since_registered;
  logic [1:0]       action;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;

  assign since_start      = item.now_ms - provisioning_start_time;
  assign since_registered = item.now_ms - last_registered_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_configured       <= 1'b0;
      recovery_timeout_ms    <= RECOVERY_TIMEOUT_RESET;
      provisioning_window_ms <= PROV_WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_CONFIGURED: start_configured       <= cfg_data[0];
        REG_RECOVERY_TIMEOUT: recovery_timeout_ms    <= cfg_data;
        REG_PROV_WINDOW:      provisioning_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_configured_next           = is_configured;
    link_up_next                 = link_up;
    connect_attempted_next       = connect_attempted;
    in_provisioning_next         = in_provisioning;
    is_registered_next           = is_registered;
    provisioning_asked_next      = provisioning_asked;
    has_deadline_next            = has_deadline;
    last_registered_time_next    = last_registered_time;
    provisioning_start_time_next = provisioning_start_time;
    action                       = ACT_NONE;

    case (item.kind)
      KIND_POLL: begin
        if (in_provisioning) begin
          // recovery provisioning gives up after the window and reconnects
          if (has_deadline && since_start >= provisioning_window_ms) begin
            in_provisioning_next      = 1'b0;
            provisioning_asked_next   = 1'b0;
            is_configured_next        = 1'b1;
            last_registered_time_next = item.now_ms;
            connect_attempted_next    = 1'b0;
            action                    = ACT_CONNECT;
          end
        end else if (!is_configured) begin
          in_provisioning_next    = 1'b1;
          provisioning_asked_next = 1'b1;
          has_deadline_next       = 1'b0;
          action                  = ACT_PROVISION;
        end else if (!is_registered && !provisioning_asked &&
                     since_registered >= recovery_timeout_ms) begin
          in_provisioning_next         = 1'b1;
          provisioning_asked_next      = 1'b1;
          provisioning_start_time_next = item.now_ms;
          has_deadline_next            = 1'b1;
          action                       = ACT_PROVISION;
        end else if (!link_up && !connect_attempted) begin
          connect_attempted_next = 1'b1;
          action                 = ACT_CONNECT;
        end
      end
      KIND_LINK: begin
        if (link_up && !item.status_flag) begin
          connect_attempted_next    = 1'b0;
          last_registered_time_next = item.now_ms;
          provisioning_asked_next   = 1'b0;
        end
        link_up_next = item.status_flag;
      end
      KIND_REGISTER: begin
        if (item.status_flag || is_registered) begin
          last_registered_time_next = item.now_ms;
          provisioning_asked_next   = 1'b0;
        end
        is_registered_next = item.status_flag;
      end
      KIND_PROV_DONE: begin
        in_provisioning_next      = 1'b0;
        provisioning_asked_next   = 1'b0;
        has_deadline_next         = 1'b0;
        is_configured_next        = 1'b1;
        last_registered_time_next = item.now_ms;
        connect_attempted_next    = 1'b0;
      end
      KIND_RESTART: begin
        is_configured_next           = start_configured;
        link_up_next                 = 1'b0;
        connect_attempted_next       = 1'b0;
        in_provisioning_next         = 1'b0;
        is_registered_next           = 1'b0;
        provisioning_asked_next      = 1'b0;
        has_deadline_next            = 1'b0;
        last_registered_time_next    = item.now_ms;
        provisioning_start_time_next = '0;
      end
      default: ;
    endcase

    res_next.action              = action;
    res_next.provisioning_active = in_provisioning_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_configured           <= 1'b0;
      link_up                 <= 1'b0;
      connect_attempted       <= 1'b0;
      in_provisioning         <= 1'b0;
      is_registered           <= 1'b0;
      provisioning_asked      <= 1'b0;
      has_deadline            <= 1'b0;
      last_registered_time    <= '0;
      provisioning_start_time <= '0;
    end else if (accept) begin
      is_configured           <= is_configured_next;
      link_up                 <= link_up_next;
      connect_attempted       <= connect_attempted_next;
      in_provisioning         <= in_provisioning_next;
      is_registered           <= is_registered_next;
      provisioning_asked      <= provisioning_asked_next;
      has_deadline            <= has_deadline_next;
      last_registered_time    <= last_registered_time_next;
      provisioning_start_time <= provisioning_start_time_next;
    end
  end

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result <= skid;
      end else if (accept) begin
        result <= res_next;
      end
    end else if (accept) begin
      skid <= res_next;
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held while output register empty");

  a_provision_sets_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action == ACT_PROVISION |-> result.provisioning_active)
    else $error("start provisioning without provisioning mode");

  a_connect_clears_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action == ACT_CONNECT |-> !result.provisioning_active)
    else $error("connect issued while still provisioning");

  a_full_buffer_stalls: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall && skid_valid |=> skid_valid)
    else $error("skid entry lost while output stalled");

endmodule

`default_nettype wire
